FILE: rtl/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg: shared types for the selective-repeat receiver window
// Field widths, result kinds, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srrw_pkg;

    localparam int SEQ_W  = 5;
    localparam int PAY_W  = 64;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTED   = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_RUN
    } t_state;

    // Read address source.
    typedef enum logic {
        RD_SEQ,
        RD_NEXT
    } t_rd_sel;

    // Write address and data source.
    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_STORE,
        WR_RETIRE
    } t_wr_sel;

    // Source of the pending delivery.
    typedef enum logic {
        PEND_INPUT,
        PEND_RDATA
    } t_pend_sel;

    typedef struct packed {
        logic              in_ready;
        logic              in_load;
        logic              rd_en;
        t_rd_sel           rd_sel;
        logic              wr_en;
        t_wr_sel           wr_sel;
        logic              clr_inc;
        logic              base_inc;
        logic              pend_load;
        t_pend_sel         pend_sel;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic pkt_ok;
        logic pkt_ack;
        logic slot_filled;
        logic in_window;
        logic behind;
        logic at_base;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/srrw_in_if.sv
// ----------------------------------------------------------------------------
// srrw_in_if: packet input channel
// Valid/ready channel that carries one received packet per item.
// ----------------------------------------------------------------------------
interface srrw_in_if;
    logic                       valid;
    logic                       ready;
    logic [srrw_pkg::SEQ_W-1:0] seq_num;
    logic                       is_ack;
    logic                       checksum_ok;
    logic                       chunk_end;
    logic [srrw_pkg::PAY_W-1:0] payload_word;

    modport source (
        output valid, seq_num, is_ack, checksum_ok, chunk_end, payload_word,
        input  ready
    );
    modport sink (
        input  valid, seq_num, is_ack, checksum_ok, chunk_end, payload_word,
        output ready
    );
endinterface

FILE: rtl/srrw_out_if.sv
// ----------------------------------------------------------------------------
// srrw_out_if: result output channel
// Valid/ready channel that carries one ack, delivery or noted result per item.
// ----------------------------------------------------------------------------
interface srrw_out_if;
    logic                        valid;
    logic                        ready;
    logic [srrw_pkg::KIND_W-1:0] kind;
    logic [srrw_pkg::SEQ_W-1:0]  out_seq;
    logic [srrw_pkg::PAY_W-1:0]  out_payload;
    logic                        out_chunk_end;
    logic                        last_of_run;

    modport source (
        output valid, kind, out_seq, out_payload, out_chunk_end, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, kind, out_seq, out_payload, out_chunk_end, last_of_run,
        output ready
    );
endinterface

FILE: rtl/srrw_ctrl.sv
// ----------------------------------------------------------------------------
// srrw_ctrl: receiver window controller
// Sequences the clearing pass, packet classification and the delivery run.
// ----------------------------------------------------------------------------
module srrw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srrw_pkg::t_sts   i_sts,
    output srrw_pkg::t_cmd   o_cmd
);

    srrw_pkg::t_state r_state;
    srrw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srrw_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_sel   = srrw_pkg::RD_SEQ;
        o_cmd.wr_sel   = srrw_pkg::WR_CLEAR;
        o_cmd.pend_sel = srrw_pkg::PEND_INPUT;
        o_cmd.out_kind = srrw_pkg::KIND_ACK;

        case (r_state)
            srrw_pkg::S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = srrw_pkg::WR_CLEAR;
                o_cmd.clr_inc = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = srrw_pkg::S_IDLE;
                end
            end
            srrw_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.in_load = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = srrw_pkg::RD_SEQ;
                    n_state       = srrw_pkg::S_DECIDE;
                end
            end
            srrw_pkg::S_DECIDE: begin
                if (!i_sts.pkt_ok) begin
                    n_state = srrw_pkg::S_IDLE;
                end else if (i_sts.pkt_ack) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = srrw_pkg::KIND_NOTED;
                        o_cmd.out_last = 1'b1;
                        n_state        = srrw_pkg::S_IDLE;
                    end
                end else if (i_sts.slot_filled || (!i_sts.in_window && i_sts.behind)) begin
                    // Duplicate, or a resend from just behind the window.
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_last = 1'b1;
                        n_state        = srrw_pkg::S_IDLE;
                    end
                end else if (i_sts.in_window) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        if (i_sts.at_base) begin
                            // The packet opens a run: ack it and hold it for delivery.
                            o_cmd.pend_load = 1'b1;
                            o_cmd.pend_sel  = srrw_pkg::PEND_INPUT;
                            o_cmd.base_inc  = 1'b1;
                            o_cmd.rd_en     = 1'b1;
                            o_cmd.rd_sel    = srrw_pkg::RD_NEXT;
                            n_state         = srrw_pkg::S_RUN;
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_sel   = srrw_pkg::WR_STORE;
                            o_cmd.out_last = 1'b1;
                            n_state        = srrw_pkg::S_IDLE;
                        end
                    end
                end else begin
                    n_state = srrw_pkg::S_IDLE;
                end
            end
            srrw_pkg::S_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = srrw_pkg::KIND_DELIVER;
                    o_cmd.out_last = !i_sts.slot_filled;
                    if (i_sts.slot_filled) begin
                        o_cmd.pend_load = 1'b1;
                        o_cmd.pend_sel  = srrw_pkg::PEND_RDATA;
                        o_cmd.wr_en     = 1'b1;
                        o_cmd.wr_sel    = srrw_pkg::WR_RETIRE;
                        o_cmd.base_inc  = 1'b1;
                        o_cmd.rd_en     = 1'b1;
                        o_cmd.rd_sel    = srrw_pkg::RD_NEXT;
                    end else begin
                        n_state = srrw_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = srrw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/srrw_dp.sv
// ----------------------------------------------------------------------------
// srrw_dp: receiver window datapath
// Packet latch, slot memory, receive base, window compares, pending delivery
// and the output register.
// ----------------------------------------------------------------------------
module srrw_dp #(
    parameter int RING_SIZE    = 32,
    parameter int WINDOW       = 8,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srrw_in_if.sink        i_pkt,
    srrw_out_if.source     o_res,
    input  srrw_pkg::t_cmd i_cmd,
    output srrw_pkg::t_sts o_sts
);

    localparam int IW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int OW = (IW > srrw_pkg::SEQ_W) ? IW : srrw_pkg::SEQ_W;
    localparam int MW = PAYLOAD_BITS + 2;
    localparam int BASE_RST = WINDOW % RING_SIZE;

    // Packet latch.
    logic [IW-1:0]           r_seq;
    logic                    r_ack;
    logic                    r_ok;
    logic                    r_end;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // Slot memory: {filled, chunk end, payload}.
    logic [MW-1:0] r_mem [RING_SIZE];
    logic [MW-1:0] r_rd;

    logic [IW-1:0] r_base;
    logic [IW-1:0] r_clr;

    logic [PAYLOAD_BITS-1:0] r_pend_payload;
    logic                    r_pend_end;
    logic [IW-1:0]           r_pend_seq;

    logic                       r_out_valid;
    logic [srrw_pkg::KIND_W-1:0] r_out_kind;
    logic [srrw_pkg::SEQ_W-1:0] r_out_seq;
    logic [srrw_pkg::PAY_W-1:0] r_out_payload;
    logic                       r_out_end;
    logic                       r_out_last;

    logic [srrw_pkg::SEQ_W-1:0] seq_red;
    logic [OW-1:0]              seq_wide;
    logic [IW-1:0]              in_idx;
    logic [IW-1:0]              base_next;
    logic [IW:0]                ahead_sum;
    logic [IW:0]                ahead;
    logic [IW:0]                behind_sum;
    logic [IW:0]                behind;
    logic [IW-1:0]              rd_addr;
    logic [IW-1:0]              wr_addr;
    logic [MW-1:0]              wr_data;
    logic [OW-1:0]              seq_ext;
    logic [OW-1:0]              pend_ext;
    logic                       out_free;

    // Sequence number reduced modulo the ring by repeated subtraction.
    always_comb begin
        seq_red = i_pkt.seq_num;
        for (int k = 0; k < 8; k++) begin
            if (32'(seq_red) >= 32'(RING_SIZE)) begin
                seq_red = seq_red - srrw_pkg::SEQ_W'(RING_SIZE);
            end
        end
        seq_wide = OW'(seq_red);
        in_idx   = seq_wide[IW-1:0];
    end

    assign base_next = (32'(r_base) == RING_SIZE - 1) ? '0 : r_base + 1'b1;

    // Distances ahead of and behind the base, each below the ring size.
    always_comb begin
        ahead_sum  = (IW+1)'(r_seq) + (IW+1)'(RING_SIZE) - (IW+1)'(r_base);
        ahead      = (32'(ahead_sum) >= 32'(RING_SIZE)) ?
                     ahead_sum - (IW+1)'(RING_SIZE) : ahead_sum;
        behind_sum = (IW+1)'(r_base) + (IW+1)'(RING_SIZE - 1) - (IW+1)'(r_seq);
        behind     = (32'(behind_sum) >= 32'(RING_SIZE)) ?
                     behind_sum - (IW+1)'(RING_SIZE) : behind_sum;
    end

    always_comb begin
        rd_addr = (i_cmd.rd_sel == srrw_pkg::RD_NEXT) ? base_next : in_idx;
        case (i_cmd.wr_sel)
            srrw_pkg::WR_STORE: begin
                wr_addr = r_seq;
                wr_data = {1'b1, r_end, r_payload};
            end
            srrw_pkg::WR_RETIRE: begin
                wr_addr = r_base;
                wr_data = '0;
            end
            default: begin
                wr_addr = r_clr;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_seq     <= in_idx;
            r_ack     <= i_pkt.is_ack;
            r_ok      <= i_pkt.checksum_ok;
            r_end     <= i_pkt.chunk_end;
            r_payload <= i_pkt.payload_word[PAYLOAD_BITS-1:0];
        end
        if (i_cmd.pend_load) begin
            r_pend_seq <= r_base;
            if (i_cmd.pend_sel == srrw_pkg::PEND_RDATA) begin
                r_pend_payload <= r_rd[PAYLOAD_BITS-1:0];
                r_pend_end     <= r_rd[PAYLOAD_BITS];
            end else begin
                r_pend_payload <= r_payload;
                r_pend_end     <= r_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= IW'(BASE_RST);
            r_clr  <= '0;
        end else begin
            if (i_cmd.base_inc) begin
                r_base <= base_next;
            end
            if (i_cmd.clr_inc) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || o_res.ready;
    assign seq_ext  = OW'(r_seq);
    assign pend_ext = OW'(r_pend_seq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_last <= i_cmd.out_last;
            if (i_cmd.out_kind == srrw_pkg::KIND_DELIVER) begin
                r_out_seq     <= pend_ext[srrw_pkg::SEQ_W-1:0];
                r_out_payload <= srrw_pkg::PAY_W'(r_pend_payload);
                r_out_end     <= r_pend_end;
            end else begin
                r_out_seq     <= seq_ext[srrw_pkg::SEQ_W-1:0];
                r_out_payload <= '0;
                r_out_end     <= 1'b0;
            end
        end
    end

    assign i_pkt.ready         = i_cmd.in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out_kind;
    assign o_res.out_seq       = r_out_seq;
    assign o_res.out_payload   = r_out_payload;
    assign o_res.out_chunk_end = r_out_end;
    assign o_res.last_of_run   = r_out_last;

    assign o_sts.in_valid    = i_pkt.valid;
    assign o_sts.pkt_ok      = r_ok;
    assign o_sts.pkt_ack     = r_ack;
    assign o_sts.slot_filled = r_rd[MW-1];
    assign o_sts.in_window   = 32'(ahead) < WINDOW;
    assign o_sts.behind      = 32'(behind) < WINDOW;
    assign o_sts.at_base     = (r_seq == r_base);
    assign o_sts.clr_last    = (32'(r_clr) == RING_SIZE - 1);
    assign o_sts.out_free    = out_free;

endmodule

FILE: rtl/selective_repeat_receiver_window_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_window_unit: selective-repeat receiver window
// Classifies arriving packets, buffers out-of-order data in a slot ring and
// delivers the in-order run that starts at the receive base.
// ----------------------------------------------------------------------------
//
//  channel  | direction | item
//  ---------+-----------+---------------------------------------------------
//  i_pkt    | in        | one packet: seq_num, is_ack, checksum_ok,
//           |           | chunk_end, payload_word
//  o_res    | out       | one result: kind, out_seq, out_payload,
//           |           | out_chunk_end, last_of_run
//
// A packet is accepted and its slot read in the idle state, then classified in the decide
// state, which loads its ack or noted result if it has one. Each delivered payload takes its
// own step in the run state, as the single read port of the slot memory looks one slot ahead
// to learn whether the run goes on. After reset a clearing pass empties every slot of the
// slot memory before the first item is accepted. A stalled output holds the controller; one
// finished result may wait in the output register while the next item is accepted.
//
module selective_repeat_receiver_window_unit #(
    parameter int RING_SIZE    = 32,
    parameter int WINDOW       = 8,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srrw_in_if.sink    i_pkt,
    srrw_out_if.source o_res
);

    // The controller sees only status flags; the datapath holds every value.
    srrw_pkg::t_cmd cmd;
    srrw_pkg::t_sts sts;

    srrw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath owns the slot memory, the receive base and the output
    // register; a packet at the base is delivered without being stored.
    srrw_dp #(
        .RING_SIZE    (RING_SIZE),
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
